@@ hw/rtl/integer_to_text_formatter_assert.svh @@
// ----------------------------------------------------------------------------
// Integer to text formatter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define ITF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ITF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/itf_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Transaction types, sequencer states, text layout and character helpers.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int MAX_FIELD_WIDTH = 48;
    localparam int MAX_DIGITS      = 32;
    localparam int DIV_STEP_BITS   = 8;
    localparam int DIV_STEPS       = VALUE_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam int DIG_IDX_W       = $clog2(MAX_DIGITS);

    localparam logic [5:0] RADIX_MIN      = 6'd2;
    localparam logic [5:0] RADIX_MAX      = 6'd36;
    localparam logic [5:0] RADIX_OCT      = 6'd8;
    localparam logic [5:0] RADIX_HEX      = 6'd16;
    localparam logic [5:0] HEX_MARK_DIGIT = 6'd33;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;

    typedef logic [5:0] t_pos;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  radix;
        logic [5:0]  field_width;
        logic [5:0]  min_digits;
        logic        left_justify;
        logic        zero_pad;
        logic        signed_mode;
        logic        force_plus;
        logic        space_sign;
        logic        alt_prefix;
        logic        upper_case;
    } t_in;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
        logic       bad_radix;
    } t_out;

    // End position (exclusive) of each text segment, and the fixed characters.
    typedef struct packed {
        t_pos       e_lead;
        t_pos       e_sign;
        t_pos       e_pfx;
        t_pos       e_zero;
        t_pos       e_dig;
        t_pos       len;
        logic [7:0] sign_ch;
        logic       upper;
    } t_layout;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LAYOUT,
        ST_EMIT,
        ST_BAD
    } t_state;

    // ASCII character of one digit value 0..35.
    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CH_ZERO + {2'b00, d};
        end else begin
            c = (upper ? CH_UP_A : CH_LO_A) + {2'b00, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/itf_divider.sv @@
// ----------------------------------------------------------------------------
// Integer to text formatter divider
// Shared restoring divider: quotient and remainder of the value by the radix,
// eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module itf_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [itf_pkg::VALUE_BITS-1:0]  i_dividend,
    input  logic [5:0]                      i_divisor,
    output logic                            o_done,
    output logic [itf_pkg::VALUE_BITS-1:0]  o_quot,
    output logic [5:0]                      o_rem
);

    logic                                r_busy;
    logic                                r_done;
    logic [itf_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [itf_pkg::VALUE_BITS-1:0]      r_work;
    logic [5:0]                          r_rem;
    logic [5:0]                          r_div;
    logic [itf_pkg::VALUE_BITS-1:0]      n_work;
    logic [5:0]                          n_rem;

    // The work register holds dividend bits still to consume at the top and
    // quotient bits collected at the bottom.
    always_comb begin
        logic [6:0] rem;
        logic [itf_pkg::VALUE_BITS-1:0] work;
        rem  = {1'b0, r_rem};
        work = r_work;
        for (int i = 0; i < itf_pkg::DIV_STEP_BITS; i++) begin
            rem  = {rem[5:0], work[itf_pkg::VALUE_BITS-1]};
            work = {work[itf_pkg::VALUE_BITS-2:0], 1'b0};
            if (rem >= {1'b0, r_div}) begin
                rem     = rem - {1'b0, r_div};
                work[0] = 1'b1;
            end
        end
        n_work = work;
        n_rem  = rem[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == itf_pkg::DIV_CNT_W'(itf_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;
    assign o_rem  = r_rem;

endmodule

@@ hw/rtl/itf_text_unit.sv @@
// ----------------------------------------------------------------------------
// Integer to text formatter text unit
// Digit store and the character selected for one position of the text.
// ----------------------------------------------------------------------------
module itf_text_unit (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [itf_pkg::DIG_IDX_W-1:0]   i_wr_idx,
    input  logic [5:0]                      i_wr_digit,
    input  itf_pkg::t_pos                   i_rd_pos,
    input  itf_pkg::t_pos                   i_rd_end,
    input  itf_pkg::t_layout                i_layout,
    input  itf_pkg::t_pos                   i_pos,
    output logic [7:0]                      o_char
);

    // Digits are stored least significant first. The read is registered, so
    // its address comes from the position and digit end of the next cycle.
    logic [5:0]                        r_digits [itf_pkg::MAX_DIGITS];
    logic [5:0]                        r_rd_digit;
    logic [itf_pkg::DIG_IDX_W-1:0]     rd_idx;
    itf_pkg::t_pos                     rd_full;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_digits[i_wr_idx] <= i_wr_digit;
        end
        r_rd_digit <= r_digits[rd_idx];
    end

    assign rd_full = i_rd_end - i_rd_pos - 6'd1;
    assign rd_idx  = rd_full[itf_pkg::DIG_IDX_W-1:0];

    always_comb begin
        if (i_pos < i_layout.e_lead) begin
            o_char = itf_pkg::CH_SPACE;
        end else if (i_pos < i_layout.e_sign) begin
            o_char = i_layout.sign_ch;
        end else if (i_pos < i_layout.e_pfx) begin
            o_char = (i_pos == i_layout.e_sign) ? itf_pkg::CH_ZERO :
                     itf_pkg::digit_char(itf_pkg::HEX_MARK_DIGIT, i_layout.upper);
        end else if (i_pos < i_layout.e_zero) begin
            o_char = itf_pkg::CH_ZERO;
        end else if (i_pos < i_layout.e_dig) begin
            o_char = itf_pkg::digit_char(r_rd_digit, i_layout.upper);
        end else begin
            o_char = itf_pkg::CH_SPACE;
        end
    end

endmodule

@@ hw/rtl/integer_to_text_formatter.sv @@
// ----------------------------------------------------------------------------
// Integer to text formatter
// printf-style conversion of one 32-bit integer into ASCII characters.
// ----------------------------------------------------------------------------
// One input transaction carries a value, a radix from 2 to 36, a field width,
// a minimum digit count and style flags; the block then returns the formatted
// text as a run of output transactions, one character each, with last_char
// set on the final one. The text is leading spaces, sign, alternate prefix,
// zero padding, precision zeros, digits and, when left justified, trailing
// spaces. A radix outside 2..36 returns a single transaction with bad_radix
// and last_char set and a NUL character. The block works on one number at a
// time: the input is ready only while the sequencer is idle. Digits come out
// of one shared restoring divider that retires eight quotient bits per cycle,
// so each digit costs one load and four divide steps; after the last digit
// and the layout step the text follows at one character per cycle when the
// output side keeps up. The output register frees the input side as soon
// as the last character is loaded, so the next number can be taken while
// that character still waits.
// ----------------------------------------------------------------------------
`include "integer_to_text_formatter_assert.svh"

module integer_to_text_formatter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itf_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output itf_pkg::t_out  o_out_data
);

    // Sequencer and output register.
    itf_pkg::t_state                  r_state;
    itf_pkg::t_state                  n_state;
    logic                             r_out_valid;
    logic                             n_out_valid;
    itf_pkg::t_out                    r_out;
    itf_pkg::t_out                    n_out;

    // Captured transaction fields, already saturated and decoded.
    logic [5:0]                       r_radix;
    logic [5:0]                       r_width;
    logic [5:0]                       r_prec;
    logic                             r_left;
    logic                             r_zpad;
    logic                             r_has_sign;
    logic [7:0]                       r_sign_ch;
    logic [1:0]                       r_pfx_len;
    logic                             r_upper;

    // Digit count, text layout and emit position.
    itf_pkg::t_pos                    r_nd;
    itf_pkg::t_layout                 r_layout;
    itf_pkg::t_layout                 n_layout;
    itf_pkg::t_pos                    r_k;
    itf_pkg::t_pos                    n_k;
    itf_pkg::t_pos                    rd_end;

    // Input decode.
    logic                             in_acc;
    logic                             radix_ok;
    logic                             in_neg;
    logic [itf_pkg::VALUE_BITS-1:0]   in_mag;
    logic                             in_has_sign;
    logic [7:0]                       in_sign_ch;
    logic [1:0]                       in_pfx_len;

    // Divider hookup.
    logic                             div_start;
    logic [itf_pkg::VALUE_BITS-1:0]   div_dividend;
    logic [5:0]                       div_divisor;
    logic                             div_done;
    logic [itf_pkg::VALUE_BITS-1:0]   div_quot;
    logic [5:0]                       div_rem;
    logic                             dig_wr;

    // Emit control.
    logic                             out_space;
    logic                             emit_fire;
    logic                             emit_last;
    logic [7:0]                       text_ch;

    // Layout arithmetic.
    itf_pkg::t_pos                    lay_p;
    logic [7:0]                       lay_pad_raw;
    itf_pkg::t_pos                    lay_pad;
    itf_pkg::t_pos                    lay_lead;
    itf_pkg::t_pos                    lay_zeros;
    itf_pkg::t_pos                    lay_trail;

    // ------------------------------------------------------------------------
    // Input side. A transaction is taken only while the sequencer is idle.
    // ------------------------------------------------------------------------
    assign o_in_ready = (r_state == itf_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        radix_ok = i_in_data.radix inside {[itf_pkg::RADIX_MIN:itf_pkg::RADIX_MAX]};
        in_neg   = i_in_data.signed_mode && i_in_data.value[itf_pkg::VALUE_BITS-1];
        // The most negative value wraps to its true unsigned magnitude.
        in_mag   = in_neg ? (~i_in_data.value + 1'b1) : i_in_data.value;

        in_has_sign = 1'b0;
        in_sign_ch  = itf_pkg::CH_NUL;
        if (i_in_data.signed_mode) begin
            if (in_neg) begin
                in_has_sign = 1'b1;
                in_sign_ch  = itf_pkg::CH_MINUS;
            end else if (i_in_data.force_plus) begin
                in_has_sign = 1'b1;
                in_sign_ch  = itf_pkg::CH_PLUS;
            end else if (i_in_data.space_sign) begin
                in_has_sign = 1'b1;
                in_sign_ch  = itf_pkg::CH_SPACE;
            end
        end

        in_pfx_len = 2'd0;
        if (i_in_data.alt_prefix) begin
            case (i_in_data.radix)
                itf_pkg::RADIX_OCT: in_pfx_len = 2'd1;
                itf_pkg::RADIX_HEX: in_pfx_len = 2'd2;
                default:            in_pfx_len = 2'd0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Digit generation. The divider is started straight from the accepted
    // transaction, then restarted on each quotient until it reaches zero. A
    // zero value still yields one zero digit on the first pass.
    // ------------------------------------------------------------------------
    assign div_start    = (in_acc && radix_ok) ||
                          ((r_state == itf_pkg::ST_DIV) && div_done && (div_quot != '0));
    assign div_dividend = (r_state == itf_pkg::ST_IDLE) ? in_mag : div_quot;
    assign div_divisor  = (r_state == itf_pkg::ST_IDLE) ? i_in_data.radix : r_radix;
    assign dig_wr       = (r_state == itf_pkg::ST_DIV) && div_done;

    itf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // The digit store read is registered and addressed by the next emit
    // position, so a digit is ready in the cycle that its position comes up.
    itf_text_unit u_text (
        .i_clk      (i_clk),
        .i_wr_en    (dig_wr),
        .i_wr_idx   (r_nd[itf_pkg::DIG_IDX_W-1:0]),
        .i_wr_digit (div_rem),
        .i_rd_pos   (n_k),
        .i_rd_end   (rd_end),
        .i_layout   (r_layout),
        .i_pos      (r_k),
        .o_char     (text_ch)
    );

    // ------------------------------------------------------------------------
    // Layout. Padding is what the field width leaves after sign, prefix and
    // the precision-extended digits, never below zero. Zero padding goes
    // between the prefix and the digits; space padding goes in front, or
    // behind when left justified.
    // ------------------------------------------------------------------------
    always_comb begin
        lay_p       = (r_nd > r_prec) ? r_nd : r_prec;
        lay_pad_raw = 8'(r_width) - 8'(r_has_sign) - 8'(r_pfx_len) - 8'(lay_p);
        lay_pad     = lay_pad_raw[7] ? '0 : lay_pad_raw[5:0];
        lay_lead    = (!r_left && !r_zpad) ? lay_pad : '0;
        lay_zeros   = (r_zpad ? lay_pad : 6'd0) + (lay_p - r_nd);
        lay_trail   = r_left ? lay_pad : '0;

        n_layout.e_lead  = lay_lead;
        n_layout.e_sign  = lay_lead + 6'(r_has_sign);
        n_layout.e_pfx   = n_layout.e_sign + 6'(r_pfx_len);
        n_layout.e_zero  = n_layout.e_pfx + lay_zeros;
        n_layout.e_dig   = n_layout.e_zero + r_nd;
        n_layout.len     = n_layout.e_dig + lay_trail;
        n_layout.sign_ch = r_sign_ch;
        n_layout.upper   = r_upper;
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            itf_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = radix_ok ? itf_pkg::ST_DIV : itf_pkg::ST_BAD;
                end
            end
            itf_pkg::ST_DIV: begin
                if (div_done && (div_quot == '0)) begin
                    n_state = itf_pkg::ST_LAYOUT;
                end
            end
            itf_pkg::ST_LAYOUT: begin
                n_state = itf_pkg::ST_EMIT;
            end
            itf_pkg::ST_EMIT: begin
                if (emit_fire && emit_last) begin
                    n_state = itf_pkg::ST_IDLE;
                end
            end
            itf_pkg::ST_BAD: begin
                if (out_space) begin
                    n_state = itf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs. In the emit and bad-radix states the output register
    // is loaded whenever it is empty or its transaction completes in this cycle.
    // ------------------------------------------------------------------------
    always_comb begin
        out_space   = !r_out_valid || i_out_ready;
        emit_last   = (r_k == (r_layout.len - 6'd1));
        emit_fire   = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            itf_pkg::ST_EMIT: begin
                if (out_space) begin
                    emit_fire   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{text_char: text_ch, last_char: emit_last, bad_radix: 1'b0};
                end
            end
            itf_pkg::ST_BAD: begin
                if (out_space) begin
                    n_out_valid = 1'b1;
                    n_out       = '{text_char: itf_pkg::CH_NUL, last_char: 1'b1,
                                    bad_radix: 1'b1};
                end
            end
            default: begin
                emit_fire = 1'b0;
            end
        endcase
    end

    // Next emit position and the digit end it is measured against. The
    // layout is not registered yet while it is being computed.
    always_comb begin
        if (r_state == itf_pkg::ST_LAYOUT) begin
            n_k    = '0;
            rd_end = n_layout.e_dig;
        end else begin
            n_k    = emit_fire ? (r_k + 6'd1) : r_k;
            rd_end = r_layout.e_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_radix    <= i_in_data.radix;
            r_width    <= (i_in_data.field_width > 6'(itf_pkg::MAX_FIELD_WIDTH)) ?
                          6'(itf_pkg::MAX_FIELD_WIDTH) : i_in_data.field_width;
            r_prec     <= (i_in_data.min_digits > 6'(itf_pkg::MAX_DIGITS)) ?
                          6'(itf_pkg::MAX_DIGITS) : i_in_data.min_digits;
            r_left     <= i_in_data.left_justify;
            r_zpad     <= i_in_data.zero_pad && !i_in_data.left_justify;
            r_has_sign <= in_has_sign;
            r_sign_ch  <= in_sign_ch;
            r_pfx_len  <= in_pfx_len;
            r_upper    <= i_in_data.upper_case;
            r_nd       <= '0;
        end else if (dig_wr) begin
            r_nd <= r_nd + 6'd1;
        end
        if (r_state == itf_pkg::ST_LAYOUT) begin
            r_layout <= n_layout;
        end
        r_k <= n_k;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `ITF_ASSERT_IMP(a_bad_form, o_out_valid && o_out_data.bad_radix,
        o_out_data.last_char && (o_out_data.text_char == itf_pkg::CH_NUL),
        "bad radix transaction is not a single NUL")
    `ITF_ASSERT_IMP(a_rem_range, (r_state == itf_pkg::ST_DIV) && div_done,
        div_rem < r_radix, "digit out of range for the radix")
    `ITF_ASSERT_IMP(a_emit_pos, r_state == itf_pkg::ST_EMIT, r_k < r_layout.len,
        "emit position past the text length")
    `ITF_ASSERT_NXT(a_one_item, in_acc, !o_in_ready,
        "input taken again before the number was formatted")

endmodule

@@ verif/integer_to_text_formatter_tb.sv @@
// ----------------------------------------------------------------------------
// Integer to text formatter testbench
// Drives formatting requests and checks every returned character.
// ----------------------------------------------------------------------------
// Each request is a 32-bit value with a radix, a field width, a minimum digit
// count and style flags. When a request transaction is accepted, a behavioral
// formatter in the scoreboard builds the full expected text and queues one
// character per expected output transaction. Each accepted output transaction
// is compared field by field with the oldest queued character. A short
// directed set covers zero, the extreme values, saturation of the width and
// precision, the sign and prefix rules and bad radixes. About 320 random
// requests follow. Both sides idle at random, except for a calm stretch in
// the middle of the random part. A watchdog ends the run if no transaction
// of either kind is accepted for too long.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_tb;

    // Style flag masks, in the order {left, zero, signed, plus, space, alt, upper}.
    localparam logic [6:0] FL_NONE   = 7'b0000000;
    localparam logic [6:0] FL_LEFT   = 7'b1000000;
    localparam logic [6:0] FL_ZPAD   = 7'b0100000;
    localparam logic [6:0] FL_SIGNED = 7'b0010000;
    localparam logic [6:0] FL_PLUS   = 7'b0001000;
    localparam logic [6:0] FL_SPACE  = 7'b0000100;
    localparam logic [6:0] FL_ALT    = 7'b0000010;
    localparam logic [6:0] FL_UPPER  = 7'b0000001;

    localparam logic [5:0] RADIX_BIN = 6'd2;
    localparam logic [5:0] RADIX_DEC = 6'd10;

    localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";
    localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    localparam int MAX_TEXT      = 48;
    localparam int RANDOM_COUNT  = 320;
    localparam int STALL_LIMIT   = 5000;
    // The slowest number has 32 binary digits; this drain after the expected
    // text covers any late output.
    localparam int DRAIN_CYCLES  = 300;

    // ------------------------------------------------------------------------
    // Scoreboard: formats each accepted request and checks the characters.
    // ------------------------------------------------------------------------
    class text_scoreboard;
        itf_pkg::t_out expected_chars[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Builds the expected text of one accepted request.
        function void note_number(itf_pkg::t_in n);
            logic [31:0]   mag;
            logic [31:0]   rem;
            logic [31:0]   base;
            logic [7:0]    sign_ch;
            logic [7:0]    digs[$];
            logic [7:0]    line[$];
            string         set;
            int            wid;
            int            prec;
            int            nd;
            int            k;
            bit            zpad;
            itf_pkg::t_out ch;

            if (n.radix < itf_pkg::RADIX_MIN || n.radix > itf_pkg::RADIX_MAX) begin
                ch.text_char = itf_pkg::CH_NUL;
                ch.last_char = 1'b1;
                ch.bad_radix = 1'b1;
                expected_chars.push_back(ch);
                return;
            end

            set  = n.upper_case ? UPPER_DIGITS : LOWER_DIGITS;
            wid  = (int'(n.field_width) > itf_pkg::MAX_FIELD_WIDTH) ?
                   itf_pkg::MAX_FIELD_WIDTH : int'(n.field_width);
            prec = (int'(n.min_digits) > itf_pkg::MAX_DIGITS) ?
                   itf_pkg::MAX_DIGITS : int'(n.min_digits);
            zpad = n.zero_pad && !n.left_justify;
            base = 32'(n.radix);

            // The sign and the prefix take room from the field width.
            mag     = n.value;
            sign_ch = itf_pkg::CH_NUL;
            if (n.signed_mode) begin
                if (n.value[31]) begin
                    sign_ch = itf_pkg::CH_MINUS;
                    mag     = 32'd0 - n.value;
                end else if (n.force_plus) begin
                    sign_ch = itf_pkg::CH_PLUS;
                end else if (n.space_sign) begin
                    sign_ch = itf_pkg::CH_SPACE;
                end
            end
            if (sign_ch != itf_pkg::CH_NUL) wid--;
            if (n.alt_prefix) begin
                if (n.radix == itf_pkg::RADIX_HEX) wid -= 2;
                else if (n.radix == itf_pkg::RADIX_OCT) wid--;
            end

            // Digits, most significant first; a zero value still gives one.
            do begin
                rem = mag % base;
                digs.push_front(set[rem]);
                mag = mag / base;
            end while (mag != 32'd0);
            nd = digs.size();
            if (nd > prec) prec = nd;
            wid -= prec;
            if (wid < 0) wid = 0;

            if (!n.left_justify && !zpad)
                for (k = 0; k < wid; k++) line.push_back(itf_pkg::CH_SPACE);
            if (sign_ch != itf_pkg::CH_NUL) line.push_back(sign_ch);
            if (n.alt_prefix && n.radix == itf_pkg::RADIX_OCT) begin
                line.push_back(itf_pkg::CH_ZERO);
            end else if (n.alt_prefix && n.radix == itf_pkg::RADIX_HEX) begin
                line.push_back(itf_pkg::CH_ZERO);
                line.push_back(set[itf_pkg::HEX_MARK_DIGIT]);
            end
            if (zpad)
                for (k = 0; k < wid; k++) line.push_back(itf_pkg::CH_ZERO);
            for (k = nd; k < prec; k++) line.push_back(itf_pkg::CH_ZERO);
            for (k = 0; k < nd; k++) line.push_back(digs[k]);
            if (n.left_justify)
                for (k = 0; k < wid; k++) line.push_back(itf_pkg::CH_SPACE);

            while (line.size() > MAX_TEXT) void'(line.pop_back());
            for (k = 0; k < line.size(); k++) begin
                ch.text_char = line[k];
                ch.last_char = (k == line.size() - 1);
                ch.bad_radix = 1'b0;
                expected_chars.push_back(ch);
            end
        endfunction

        // Compares one accepted character with the oldest expectation.
        function void check_char(itf_pkg::t_out got);
            itf_pkg::t_out want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.text_char !== want.text_char) begin
                $display("%0t: text_char expected %h got %h",
                         $time, want.text_char, got.text_char);
                mismatches++;
            end
            if (got.last_char !== want.last_char) begin
                $display("%0t: last_char expected %b got %b",
                         $time, want.last_char, got.last_char);
                mismatches++;
            end
            if (got.bad_radix !== want.bad_radix) begin
                $display("%0t: bad_radix expected %b got %b",
                         $time, want.bad_radix, got.bad_radix);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test.
    // ------------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_ready = 1'b0;
    itf_pkg::t_in  i_in_data   = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    itf_pkg::t_out o_out_data;

    // While calm is set, neither side idles.
    bit calm = 1'b0;

    text_scoreboard text_sb = new();

    integer_to_text_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Request helpers.
    // ------------------------------------------------------------------------
    function automatic itf_pkg::t_in number_item(logic [31:0] v, logic [5:0] r,
                                                 logic [5:0] w, logic [5:0] p,
                                                 logic [6:0] flags);
        itf_pkg::t_in n;
        n.value       = v;
        n.radix       = r;
        n.field_width = w;
        n.min_digits  = p;
        {n.left_justify, n.zero_pad, n.signed_mode, n.force_plus,
         n.space_sign, n.alt_prefix, n.upper_case} = flags;
        return n;
    endfunction

    // Random request, leaning toward small values, the sign boundary and
    // the radixes that carry a prefix; some radixes are invalid.
    function automatic itf_pkg::t_in random_number();
        itf_pkg::t_in n;
        int           pick;
        logic [31:0]  v;
        logic [5:0]   r;
        logic [5:0]   w;
        logic [5:0]   p;

        pick = $urandom_range(0, 99);
        if (pick < 20)      v = $urandom_range(0, 40);
        else if (pick < 30) v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                ^ $urandom_range(0, 3);
        else if (pick < 40) v = 32'd0 - $urandom_range(0, 300);
        else                v = $urandom();

        pick = $urandom_range(0, 99);
        if (pick < 15)      r = 6'($urandom_range(0, 63));
        else if (pick < 30) r = itf_pkg::RADIX_HEX;
        else if (pick < 45) r = itf_pkg::RADIX_OCT;
        else if (pick < 60) r = RADIX_DEC;
        else                r = 6'($urandom_range(2, 36));

        w = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 20))
                                         : 6'($urandom_range(0, 63));
        p = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 12))
                                         : 6'($urandom_range(0, 63));
        n = number_item(v, r, w, p, 7'($urandom_range(0, 127)));
        return n;
    endfunction

    // Presents one request and holds it until the block takes it. Valid is
    // only lowered for an idle gap, so a back-to-back request keeps it high.
    task automatic send_number(itf_pkg::t_in n);
        i_in_valid <= 1'b1;
        i_in_data  <= n;
        do @(posedge i_clk); while (!o_in_ready);
        text_sb.note_number(n);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each accepted character, then pick the next ready.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                text_sb.check_char(o_out_data);
            i_out_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles without any accepted transaction is a hang.
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[integer_to_text_formatter] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int i;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero in plain decimal, and with the octal and hex prefixes.
        send_number(number_item(32'd0, RADIX_DEC, 6'd0, 6'd0, FL_NONE));
        send_number(number_item(32'd0, itf_pkg::RADIX_OCT, 6'd0, 6'd0, FL_ALT));
        send_number(number_item(32'd0, itf_pkg::RADIX_HEX, 6'd5, 6'd0, FL_ALT));
        // All ones in binary gives the longest digit string.
        send_number(number_item(32'hFFFF_FFFF, RADIX_BIN, 6'd48, 6'd0, FL_NONE));
        send_number(number_item(32'hFFFF_FFFF, RADIX_BIN, 6'd63, 6'd63, FL_ZPAD));
        // The most negative value prints its true magnitude.
        send_number(number_item(32'h8000_0000, RADIX_DEC, 6'd0, 6'd0, FL_SIGNED));
        send_number(number_item(32'h8000_0000, RADIX_BIN, 6'd0, 6'd0, FL_SIGNED));
        send_number(number_item(32'hFFFF_FFFF, RADIX_DEC, 6'd10, 6'd0,
                                FL_SIGNED | FL_PLUS | FL_ZPAD));
        // Sign choices for values that are not negative.
        send_number(number_item(32'h7FFF_FFFF, RADIX_DEC, 6'd14, 6'd0,
                                FL_SIGNED | FL_PLUS | FL_ZPAD));
        send_number(number_item(32'd42, RADIX_DEC, 6'd6, 6'd0, FL_SIGNED | FL_SPACE));
        send_number(number_item(32'd42, RADIX_DEC, 6'd6, 6'd0,
                                FL_SIGNED | FL_PLUS | FL_SPACE));
        // Sign flags without signed mode are ignored.
        send_number(number_item(32'hFFFF_FFFF, RADIX_DEC, 6'd0, 6'd0, FL_PLUS | FL_SPACE));
        // Left justification cancels zero padding.
        send_number(number_item(32'd1234, RADIX_DEC, 6'd20, 6'd6,
                                FL_LEFT | FL_ZPAD | FL_SIGNED | FL_PLUS));
        send_number(number_item(32'hDEAD_BEEF, itf_pkg::RADIX_HEX, 6'd12, 6'd0,
                                FL_ALT | FL_UPPER | FL_ZPAD));
        send_number(number_item(32'hDEAD_BEEF, itf_pkg::RADIX_HEX, 6'd12, 6'd0,
                                FL_ALT | FL_LEFT));
        send_number(number_item(32'd8_675_309, itf_pkg::RADIX_OCT, 6'd0, 6'd12, FL_ALT));
        // Largest radix in both cases; the prefix has no effect here.
        send_number(number_item(32'hFFFF_FFFF, itf_pkg::RADIX_MAX, 6'd0, 6'd0,
                                FL_UPPER | FL_ALT));
        send_number(number_item(32'hFFFF_FFFF, itf_pkg::RADIX_MAX, 6'd0, 6'd0, FL_NONE));
        send_number(number_item(32'd12345, RADIX_DEC, 6'd9, 6'd0, FL_ALT));
        // Precision and width above and at their limits.
        send_number(number_item(32'd7, RADIX_DEC, 6'd63, 6'd40, FL_SIGNED | FL_SPACE));
        send_number(number_item(32'd7, RADIX_DEC, 6'd48, 6'd32, FL_LEFT));
        // Invalid radixes on both sides of the valid range.
        send_number(number_item(32'd5, 6'd0, 6'd10, 6'd0, FL_NONE));
        send_number(number_item(32'd5, 6'd1, 6'd10, 6'd0, FL_SIGNED));
        send_number(number_item(32'd5, 6'd37, 6'd0, 6'd0, FL_ALT));
        send_number(number_item(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 7'b1111111));

        // Random part, with a stretch in the middle where nothing idles.
        for (i = 0; i < RANDOM_COUNT; i++) begin
            calm = (i >= 120 && i < 200);
            send_number(random_number());
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Wait for the text still due, then for any stray characters.
        while (text_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_sb.mismatches == 0) begin
            $display("[integer_to_text_formatter] OK");
        end else begin
            $display("[integer_to_text_formatter] ERROR");
        end
        $finish;
    end

endmodule
